@@ rtl/core/dlf_pkg.sv @@
// ----------------------------------------------------------------------------
// dlf_pkg
// Shared constants and types of the line rasterizer with its one-bit frame.
// ----------------------------------------------------------------------------
`default_nettype none

package dlf_pkg;

  localparam int FRAME_WIDTH  = 64;
  localparam int FRAME_HEIGHT = 64;

  localparam int COL_W   = (FRAME_WIDTH > 1) ? $clog2(FRAME_WIDTH) : 1;
  localparam int ROW_W   = (FRAME_HEIGHT > 1) ? $clog2(FRAME_HEIGHT) : 1;
  localparam int COORD_W = 9;
  // Point coordinate: start plus signed offset of up to 511.
  localparam int PT_W    = COORD_W + 2;
  localparam int MAG_W   = COORD_W;

  typedef enum logic [1:0] {
    KIND_CLEAR = 2'd0,
    KIND_DRAW  = 2'd1,
    KIND_READ  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DRAW,
    ST_DRAIN,
    ST_READ,
    ST_RESULT
  } state_t;

  // One plotted point from the stepper.
  typedef struct packed {
    logic             last;
    logic             in_frame;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } point_t;

  // One access to the frame memory.
  typedef struct packed {
    logic             write;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } acc_t;

endpackage

`default_nettype wire

@@ rtl/core/dda_line_framebuffer.sv @@
// ----------------------------------------------------------------------------
// dda_line_framebuffer
// Command front end: clear, draw a line, read a pixel; one result per item.
// ----------------------------------------------------------------------------
// Clear, unused kind and off-frame read go straight to ST_RESULT; a read passes
// ST_READ, a draw ST_DRAW and ST_DRAIN first, then the output register loads.
// One item at a time: the next is accepted once the result leaves ST_RESULT,
// which any output stall delays; a draw plots one point per cycle.
// Reset clears the per-row valid flags at once, so the frame reads blank on
// the next cycle; no clearing pass runs.
`default_nettype none

module dda_line_framebuffer (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [1:0]                           kind,
  input  wire logic signed [dlf_pkg::COORD_W-1:0]   start_x,
  input  wire logic signed [dlf_pkg::COORD_W-1:0]   start_y,
  input  wire logic signed [dlf_pkg::COORD_W-1:0]   end_x,
  input  wire logic signed [dlf_pkg::COORD_W-1:0]   end_y,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic                                      pixel
);

  dlf_pkg::state_t state;
  dlf_pkg::state_t state_next;

  logic            read_in_frame;
  logic            out_free;
  logic            res_bit;

  logic            step_start;
  logic            step_advance;
  dlf_pkg::point_t point;

  logic            frame_clear;
  logic            acc_valid;
  dlf_pkg::acc_t   acc;
  logic            rd_bit;

  logic            res_load;
  logic            res_from_mem;

  dlf_stepper u_stepper (
    .clk     (clk),
    .start   (step_start),
    .advance (step_advance),
    .x0_in   (start_x),
    .y0_in   (start_y),
    .x1_in   (end_x),
    .y1_in   (end_y),
    .point   (point)
  );

  dlf_frame u_frame (
    .clk       (clk),
    .rst       (rst),
    .clear     (frame_clear),
    .acc_valid (acc_valid),
    .acc       (acc),
    .rd_bit    (rd_bit)
  );

  assign out_free = !out_valid || !out_stall;
  assign read_in_frame =
    !start_x[dlf_pkg::COORD_W-1] &&
    ({1'b0, start_x[dlf_pkg::COORD_W-2:0]} < dlf_pkg::COORD_W'(dlf_pkg::FRAME_WIDTH)) &&
    !start_y[dlf_pkg::COORD_W-1] &&
    ({1'b0, start_y[dlf_pkg::COORD_W-2:0]} < dlf_pkg::COORD_W'(dlf_pkg::FRAME_HEIGHT));

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      dlf_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (dlf_pkg::kind_t'(kind))
            dlf_pkg::KIND_DRAW: state_next = dlf_pkg::ST_DRAW;
            dlf_pkg::KIND_READ: state_next = read_in_frame ? dlf_pkg::ST_READ
                                                           : dlf_pkg::ST_RESULT;
            default:            state_next = dlf_pkg::ST_RESULT;
          endcase
        end
      end
      dlf_pkg::ST_DRAW: begin
        if (point.last) begin
          state_next = dlf_pkg::ST_DRAIN;
        end
      end
      dlf_pkg::ST_DRAIN:  state_next = dlf_pkg::ST_RESULT;
      dlf_pkg::ST_READ:   state_next = dlf_pkg::ST_RESULT;
      dlf_pkg::ST_RESULT: begin
        if (out_free) begin
          state_next = dlf_pkg::ST_IDLE;
        end
      end
      default: state_next = dlf_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_stall     = 1'b1;
    step_start   = 1'b0;
    step_advance = 1'b0;
    frame_clear  = 1'b0;
    acc_valid    = 1'b0;
    acc.write    = 1'b1;
    acc.row      = point.row;
    acc.col      = point.col;
    res_load     = 1'b0;
    res_from_mem = 1'b0;
    case (state)
      dlf_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        res_load = in_valid;
        if (in_valid) begin
          case (dlf_pkg::kind_t'(kind))
            dlf_pkg::KIND_CLEAR: frame_clear = 1'b1;
            dlf_pkg::KIND_DRAW:  step_start  = 1'b1;
            dlf_pkg::KIND_READ: begin
              acc_valid = read_in_frame;
              acc.write = 1'b0;
              acc.row   = start_y[dlf_pkg::ROW_W-1:0];
              acc.col   = start_x[dlf_pkg::COL_W-1:0];
            end
            default: ;
          endcase
        end
      end
      dlf_pkg::ST_DRAW: begin
        step_advance = 1'b1;
        acc_valid    = point.in_frame;
      end
      dlf_pkg::ST_READ: begin
        res_load     = 1'b1;
        res_from_mem = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_bit <= res_from_mem ? rd_bit : 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == dlf_pkg::ST_RESULT) && out_free) begin
      pixel <= res_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dlf_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == dlf_pkg::ST_RESULT) && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/dlf_stepper.sv @@
// ----------------------------------------------------------------------------
// dlf_stepper
// Walks the points of one line, one point per cycle while advance is high. Each
// coordinate keeps a running quotient and remainder of i*|d|/steps; no divider.
// ----------------------------------------------------------------------------
`default_nettype none

module dlf_stepper (
  input  wire logic                                 clk,
  input  wire logic                                 start,
  input  wire logic                                 advance,
  input  wire logic signed [dlf_pkg::COORD_W-1:0]   x0_in,
  input  wire logic signed [dlf_pkg::COORD_W-1:0]   y0_in,
  input  wire logic signed [dlf_pkg::COORD_W-1:0]   x1_in,
  input  wire logic signed [dlf_pkg::COORD_W-1:0]   y1_in,
  output dlf_pkg::point_t                           point
);

  logic signed [dlf_pkg::COORD_W-1:0] x0;
  logic signed [dlf_pkg::COORD_W-1:0] y0;
  logic [dlf_pkg::MAG_W-1:0]          adx;
  logic [dlf_pkg::MAG_W-1:0]          ady;
  logic                               neg_x;
  logic                               neg_y;
  logic [dlf_pkg::MAG_W-1:0]          steps;
  logic [dlf_pkg::MAG_W-1:0]          cnt;
  logic [dlf_pkg::MAG_W-1:0]          qx;
  logic [dlf_pkg::MAG_W-1:0]          qy;
  logic [dlf_pkg::MAG_W-1:0]          rx;
  logic [dlf_pkg::MAG_W-1:0]          ry;

  logic signed [dlf_pkg::COORD_W:0]   dx_s;
  logic signed [dlf_pkg::COORD_W:0]   dy_s;
  logic [dlf_pkg::COORD_W:0]          dx_abs;
  logic [dlf_pkg::COORD_W:0]          dy_abs;
  logic [dlf_pkg::MAG_W:0]            rx_sum;
  logic [dlf_pkg::MAG_W:0]            ry_sum;
  logic [dlf_pkg::MAG_W:0]            rx_sub;
  logic [dlf_pkg::MAG_W:0]            ry_sub;
  logic signed [dlf_pkg::PT_W-1:0]    off_x;
  logic signed [dlf_pkg::PT_W-1:0]    off_y;
  logic signed [dlf_pkg::PT_W-1:0]    px;
  logic signed [dlf_pkg::PT_W-1:0]    py;

  always_comb begin
    dx_s   = {x1_in[dlf_pkg::COORD_W-1], x1_in} - {x0_in[dlf_pkg::COORD_W-1], x0_in};
    dy_s   = {y1_in[dlf_pkg::COORD_W-1], y1_in} - {y0_in[dlf_pkg::COORD_W-1], y0_in};
    dx_abs = dx_s[dlf_pkg::COORD_W] ? -dx_s : dx_s;
    dy_abs = dy_s[dlf_pkg::COORD_W] ? -dy_s : dy_s;
  end

  always_comb begin
    rx_sum = {1'b0, rx} + {1'b0, adx};
    ry_sum = {1'b0, ry} + {1'b0, ady};
    rx_sub = rx_sum - {1'b0, steps};
    ry_sub = ry_sum - {1'b0, steps};
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x0    <= x0_in;
      y0    <= y0_in;
      adx   <= dx_abs[dlf_pkg::MAG_W-1:0];
      ady   <= dy_abs[dlf_pkg::MAG_W-1:0];
      neg_x <= dx_s[dlf_pkg::COORD_W];
      neg_y <= dy_s[dlf_pkg::COORD_W];
      steps <= (dx_abs > dy_abs) ? dx_abs[dlf_pkg::MAG_W-1:0]
                                 : dy_abs[dlf_pkg::MAG_W-1:0];
      cnt   <= '0;
      qx    <= '0;
      qy    <= '0;
      rx    <= '0;
      ry    <= '0;
    end else if (advance) begin
      cnt <= cnt + 1'b1;
      // Remainder stays below steps and |d| <= steps, so one subtract wraps it.
      if (rx_sum >= {1'b0, steps}) begin
        rx <= rx_sub[dlf_pkg::MAG_W-1:0];
        qx <= qx + 1'b1;
      end else begin
        rx <= rx_sum[dlf_pkg::MAG_W-1:0];
      end
      if (ry_sum >= {1'b0, steps}) begin
        ry <= ry_sub[dlf_pkg::MAG_W-1:0];
        qy <= qy + 1'b1;
      end else begin
        ry <= ry_sum[dlf_pkg::MAG_W-1:0];
      end
    end
  end

  always_comb begin
    off_x = neg_x ? -$signed({2'b00, qx}) : $signed({2'b00, qx});
    off_y = neg_y ? -$signed({2'b00, qy}) : $signed({2'b00, qy});
    px    = {{(dlf_pkg::PT_W-dlf_pkg::COORD_W){x0[dlf_pkg::COORD_W-1]}}, x0} + off_x;
    py    = {{(dlf_pkg::PT_W-dlf_pkg::COORD_W){y0[dlf_pkg::COORD_W-1]}}, y0} + off_y;

    point.last     = (cnt == steps);
    point.in_frame = !px[dlf_pkg::PT_W-1] &&
                     (px[dlf_pkg::PT_W-2:0] < (dlf_pkg::PT_W-1)'(dlf_pkg::FRAME_WIDTH)) &&
                     !py[dlf_pkg::PT_W-1] &&
                     (py[dlf_pkg::PT_W-2:0] < (dlf_pkg::PT_W-1)'(dlf_pkg::FRAME_HEIGHT));
    point.col      = px[dlf_pkg::COL_W-1:0];
    // Flip y so row 0 is the top.
    point.row      = dlf_pkg::ROW_W'(dlf_pkg::FRAME_HEIGHT - 1) - py[dlf_pkg::ROW_W-1:0];
  end

endmodule

`default_nettype wire

@@ rtl/core/dlf_frame.sv @@
// ----------------------------------------------------------------------------
// dlf_frame
// Frame memory, one row per word, with per-row valid flags. Sets a pixel by
// read-modify-write over two stages; forwards the last written row.
// ----------------------------------------------------------------------------
`default_nettype none

module dlf_frame (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          clear,
  input  wire logic          acc_valid,
  input  wire dlf_pkg::acc_t acc,
  output logic               rd_bit
);

  logic [dlf_pkg::FRAME_WIDTH-1:0] mem [dlf_pkg::FRAME_HEIGHT];
  logic [dlf_pkg::FRAME_WIDTH-1:0] rdata;
  logic [dlf_pkg::FRAME_HEIGHT-1:0] row_valid;

  logic                            s2_valid;
  dlf_pkg::acc_t                   s2_acc;

  logic                            fwd_valid;
  logic [dlf_pkg::ROW_W-1:0]       fwd_row;
  logic [dlf_pkg::FRAME_WIDTH-1:0] fwd_data;

  logic [dlf_pkg::FRAME_WIDTH-1:0] row_word;
  logic [dlf_pkg::FRAME_WIDTH-1:0] new_word;
  logic                            do_write;

  always_comb begin
    // A row written last cycle is not yet in the read data: take the copy.
    if (fwd_valid && (fwd_row == s2_acc.row)) begin
      row_word = fwd_data;
    end else if (row_valid[s2_acc.row]) begin
      row_word = rdata;
    end else begin
      row_word = '0;
    end
    new_word = row_word | (dlf_pkg::FRAME_WIDTH'(1) << s2_acc.col);
    do_write = s2_valid && s2_acc.write;
    rd_bit   = row_word[s2_acc.col];
  end

  always_ff @(posedge clk) begin
    if (acc_valid) begin
      rdata <= mem[acc.row];
    end
  end

  always_ff @(posedge clk) begin
    if (do_write) begin
      mem[s2_acc.row] <= new_word;
    end
  end

  always_ff @(posedge clk) begin
    s2_acc   <= acc;
    fwd_row  <= s2_acc.row;
    fwd_data <= new_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid  <= 1'b0;
      fwd_valid <= 1'b0;
      row_valid <= '0;
    end else begin
      s2_valid  <= acc_valid;
      fwd_valid <= do_write;
      if (clear) begin
        row_valid <= '0;
      end else if (do_write) begin
        row_valid[s2_acc.row] <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ dv/dda_line_framebuffer_test.sv @@
// ----------------------------------------------------------------------------
// dda_line_framebuffer_test
// Self-checking bench for the line rasterizer and its one-bit frame. Clears,
// line draws, pixel reads and the unused command kind go in under random
// idling on both sides. A scoreboard keeps its own copy of the frame, plots
// each accepted line into it, and checks every returned pixel in order.
// ----------------------------------------------------------------------------
module dda_line_framebuffer_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = dlf_pkg::COORD_W;
  localparam int FW = dlf_pkg::FRAME_WIDTH;
  localparam int FH = dlf_pkg::FRAME_HEIGHT;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1250;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int HOLD_CYCLES = 400;

  class frame_scoreboard;
    bit [FW*FH-1:0] lit;
    bit             pixel_queue[$];
    int             mismatches, results;
    int             clears, draws, reads, lit_reads, unused;

    static function int line_steps(int x0, int y0, int x1, int y1);
      int adx, ady;
      adx = (x1 > x0) ? x1 - x0 : x0 - x1;
      ady = (y1 > y0) ? y1 - y0 : y0 - y1;
      return (adx > ady) ? adx : ady;
    endfunction

    // Point i of the line, divisions truncating toward zero.
    static function void line_point(int x0, int y0, int x1, int y1, int i,
                                    output int px, output int py);
      int steps;
      steps = line_steps(x0, y0, x1, y1);
      if (steps == 0) begin
        px = x0;
        py = y0;
      end else begin
        px = x0 + (i * (x1 - x0)) / steps;
        py = y0 + (i * (y1 - y0)) / steps;
      end
    endfunction

    function void note_item(logic [1:0] k, int sx, int sy, int ex, int ey);
      int steps, px, py;
      bit val;
      val = 1'b0;
      case (k)
        dlf_pkg::KIND_CLEAR: begin
          lit = '0;
          clears++;
        end
        dlf_pkg::KIND_DRAW: begin
          steps = line_steps(sx, sy, ex, ey);
          for (int i = 0; i <= steps; i++) begin
            line_point(sx, sy, ex, ey, i, px, py);
            // drop points off the frame; flip y to a top-down row
            if (px >= 0 && px < FW && py >= 0 && py < FH)
              lit[(FH - 1 - py) * FW + px] = 1'b1;
          end
          draws++;
        end
        dlf_pkg::KIND_READ: begin
          if (sx >= 0 && sx < FW && sy >= 0 && sy < FH)
            val = lit[sy * FW + sx];
          reads++;
          if (val) lit_reads++;
        end
        default: unused++;
      endcase
      pixel_queue.push_back(val);
    endfunction

    function void check_pixel(logic actual);
      bit want;
      results++;
      if (pixel_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result %0d: pixel %0b with nothing pending",
                   results, actual);
        return;
      end
      want = pixel_queue.pop_front();
      if (actual !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("pixel mismatch on result %0d: expected %0b, got %0b",
                   results, want, actual);
      end
    endfunction

    function int pending();
      return pixel_queue.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           kind = dlf_pkg::KIND_CLEAR;
  logic signed [CW-1:0] start_x = '0;
  logic signed [CW-1:0] start_y = '0;
  logic signed [CW-1:0] end_x = '0;
  logic signed [CW-1:0] end_y = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 pixel;

  frame_scoreboard sb = new();
  bit              hold_req;
  bit              quiet_rx;
  int              cycles;

  dda_line_framebuffer u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .start_x   (start_x),
    .start_y   (start_y),
    .end_x     (end_x),
    .end_y     (end_y),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pixel     (pixel)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Mostly short gaps, a few long ones.
  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic int rand_coord(bit near_frame);
    if (near_frame) return $urandom_range(0, FW + 15) - 8;
    return $urandom_range(0, 511) - 256;
  endfunction

  task automatic send_item(logic [1:0] k, int sx, int sy, int ex, int ey);
    in_valid <= 1'b1;
    kind     <= k;
    start_x  <= sx[CW-1:0];
    start_y  <= sy[CW-1:0];
    end_x    <= ex[CW-1:0];
    end_y    <= ey[CW-1:0];
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    sb.note_item(k, sx, sy, ex, ey);
  endtask

  task automatic idle_sender(int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    idle_sender(1);
    while (sb.pending() > 0) @(posedge clk);
  endtask

  // Receiver stall pattern; a requested hold-off is counted here.
  initial begin
    int n;
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        n = quiet_rx ? 0 : rand_gap();
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
    end
  end

  // Inputs settle after the edge, so a result sampled here fires next edge.
  always @(negedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_pixel(pixel);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    quiet_rx <= ((cycles / 3000) % 5) == 3;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("dda_line_framebuffer_test: errors");
      $finish;
    end
  end

  initial begin
    int k_sel, sx, sy, ex, ey, px, py;
    int lx0, ly0, lx1, ly1;
    bit have_line, quiet_tx;
    cycles = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed part
    send_item(dlf_pkg::KIND_READ, 0, 0, 0, 0);
    send_item(dlf_pkg::KIND_DRAW, 5, 7, 5, 7);              // zero-length line
    send_item(dlf_pkg::KIND_READ, 5, FH - 1 - 7, 0, 0);
    send_item(dlf_pkg::KIND_DRAW, -256, -256, 255, 255);    // crosses the frame
    send_item(dlf_pkg::KIND_READ, 10, FH - 1 - 10, 0, 0);
    send_item(dlf_pkg::KIND_DRAW, 255, -256, -256, 255);
    send_item(dlf_pkg::KIND_DRAW, 0, 0, FW - 1, 0);
    send_item(dlf_pkg::KIND_READ, FW - 1, FH - 1, 0, 0);
    send_item(dlf_pkg::KIND_DRAW, 0, 0, 0, FH - 1);
    send_item(dlf_pkg::KIND_READ, 0, 0, 0, 0);
    send_item(dlf_pkg::KIND_DRAW, 100, 100, 200, 150);      // entirely off the frame
    send_item(dlf_pkg::KIND_DRAW, 3, 1, 10, 60);
    send_item(dlf_pkg::KIND_READ, 7, FH - 1 - 34, 0, 0);
    send_item(dlf_pkg::KIND_READ, -1, 0, 0, 0);
    send_item(dlf_pkg::KIND_READ, FW, 0, 0, 0);
    send_item(dlf_pkg::KIND_READ, 0, FH, 0, 0);
    send_item(dlf_pkg::KIND_READ, 0, -1, 0, 0);
    send_item(dlf_pkg::KIND_READ, -256, 255, 0, 0);
    send_item(dlf_pkg::KIND_READ, 255, -256, 0, 0);
    send_item(KIND_UNUSED, -256, 255, -1, 85);
    send_item(dlf_pkg::KIND_CLEAR, 255, -256, 170, -171);
    send_item(dlf_pkg::KIND_READ, 5, FH - 1 - 7, 0, 0);
    send_item(dlf_pkg::KIND_READ, 0, 0, 0, 0);

    have_line = 1'b0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      quiet_tx = ((n / 150) % 4) == 2;
      if (n == 300) hold_req = 1'b1;          // keep offering while held off
      if (n == 650) wait_drained();
      sx = 0; sy = 0; ex = 0; ey = 0;
      k_sel = $urandom_range(0, 99);
      if (k_sel < 3) begin
        ex = rand_coord(0);
        ey = rand_coord(0);
        send_item(dlf_pkg::KIND_CLEAR, rand_coord(0), rand_coord(0), ex, ey);
      end else if (k_sel < 43) begin
        k_sel = $urandom_range(0, 19);
        sx = rand_coord(k_sel < 15);
        sy = rand_coord(k_sel < 15);
        ex = (k_sel == 19) ? sx : rand_coord(k_sel < 15);
        ey = (k_sel == 19) ? sy : rand_coord(k_sel < 15);
        send_item(dlf_pkg::KIND_DRAW, sx, sy, ex, ey);
        lx0 = sx; ly0 = sy; lx1 = ex; ly1 = ey;
        have_line = 1'b1;
      end else if (k_sel < 95) begin
        k_sel = $urandom_range(0, 19);
        if (have_line && k_sel < 9) begin
          // aim at a point of the last line
          frame_scoreboard::line_point(lx0, ly0, lx1, ly1,
              $urandom_range(0, frame_scoreboard::line_steps(lx0, ly0, lx1, ly1)),
              px, py);
          sx = px;
          sy = FH - 1 - py;
        end else if (k_sel < 17) begin
          sx = $urandom_range(0, FW - 1);
          sy = $urandom_range(0, FH - 1);
        end else begin
          sx = rand_coord(0);
          sy = rand_coord(0);
        end
        if (sx < -256 || sx > 255) sx = 0;
        if (sy < -256 || sy > 255) sy = 0;
        send_item(dlf_pkg::KIND_READ, sx, sy, rand_coord(0), rand_coord(0));
      end else begin
        send_item(KIND_UNUSED, rand_coord(0), rand_coord(0), rand_coord(0),
                  rand_coord(0));
      end
      if (!quiet_tx && !hold_req) idle_sender(rand_gap());
    end

    wait_drained();
    repeat (16) @(posedge clk);

    $display("covered %0d clears, %0d line draws, %0d reads (%0d on set pixels), %0d unused",
             sb.clears, sb.draws, sb.reads, sb.lit_reads, sb.unused);
    $display("%0d results checked, %0d mismatches, %0d still pending",
             sb.results, sb.mismatches, sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("dda_line_framebuffer_test: clean");
    end else begin
      $display("dda_line_framebuffer_test: errors");
    end
    $finish;
  end

endmodule
